// ===== hw/rtl/svf_pkg.sv =====
// svf_pkg: widths, register indexes, response codes and shared helpers
// for the state variable filter core. No dependencies.
package svf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int VAL_W      = 40;
  localparam int COEF_W     = 32;
  localparam int SUM_W      = VAL_W + 3;
  localparam int SEL_W      = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_D     = 24;
  localparam int FRAC_G     = 28;

  localparam logic [1:0] REG_SEL  = 2'd0;
  localparam logic [1:0] REG_G    = 2'd1;
  localparam logic [1:0] REG_DAMP = 2'd2;
  localparam logic [1:0] REG_H    = 2'd3;

  localparam logic [SEL_W-1:0] RESP_LP = 2'd0;
  localparam logic [SEL_W-1:0] RESP_BP = 2'd1;
  localparam logic [SEL_W-1:0] RESP_HP = 2'd2;

  localparam logic [COEF_W-1:0] COEF_H_RST = 32'h1000_0000;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
    logic frac24;
  } mul_ctl_t;

  localparam sum_t SUM_MAX = {{(SUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {{(SUM_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  function automatic sum_t ext(input val_t v);
    return SUM_W'(v);
  endfunction

  function automatic val_t sat_val(input sum_t v);
    val_t r;
    if (v > SUM_MAX) begin
      r = SUM_MAX[VAL_W-1:0];
    end else if (v < SUM_MIN) begin
      r = SUM_MIN[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/svf_mulc.sv =====
// svf_mulc: shared coefficient multiplier, one 40x17 multiplier used in two
// passes (low then high coefficient half), rounded and saturated result.
// Depends on svf_pkg.
module svf_mulc (
  input  logic                          clk,
  input  svf_pkg::mul_ctl_t             ctl,
  input  svf_pkg::val_t                 opnd,
  input  logic [svf_pkg::COEF_W-1:0]    coef,
  output svf_pkg::val_t                 res
);
  import svf_pkg::*;

  localparam int HALF_W = COEF_W / 2;
  localparam int PROD_W = VAL_W + HALF_W + 1;
  localparam int ACC_W  = VAL_W + COEF_W + 2;

  localparam logic signed [PROD_W-1:0] RND_D = PROD_W'(2 ** (FRAC_D - 1));
  localparam logic signed [PROD_W-1:0] RND_G = PROD_W'(2 ** (FRAC_G - 1));
  localparam logic signed [ACC_W-1:0] LIM_MAX =
    {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] LIM_MIN =
    {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  logic [HALF_W-1:0]         c_half;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]   full;
  logic signed [ACC_W-1:0]   shifted;
  val_t                      res_r;
  val_t                      res_nxt;

  assign c_half = ctl.hi_en ? coef[COEF_W-1:HALF_W] : coef[HALF_W-1:0];
  assign prod   = opnd * $signed({1'b0, c_half});
  assign full   = (ACC_W'(prod) <<< HALF_W) + ACC_W'(acc_r);
  assign shifted = ctl.frac24 ? (full >>> FRAC_D) : (full >>> FRAC_G);

  always_comb begin
    if (shifted > LIM_MAX) begin
      res_nxt = LIM_MAX[VAL_W-1:0];
    end else if (shifted < LIM_MIN) begin
      res_nxt = LIM_MIN[VAL_W-1:0];
    end else begin
      res_nxt = shifted[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lo_en) begin
      acc_r <= prod + (ctl.frac24 ? RND_D : RND_G);
    end
    if (ctl.hi_en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/state_variable_filter_core.sv =====
// state_variable_filter_core: trapezoidal state variable filter, top level
// with register port, sequencer and integrators. Depends on svf_pkg, svf_mulc.
//
//   channel  ports                                   role
//   in       in_valid/in_ready, in_sample_in         input sample beat
//   out      out_valid/out_ready, out_sample_out     selected response beat
//   cfg      cfg_psel..cfg_pready, 4-bit byte addr   coefficient registers
//
// one sample passes through an accept step in idle and twelve sequencer steps
// four coefficient products, each two passes through the single 40x17 multiplier
// reset is synchronous: integrators zero, response lowpass, g and damp zero, h one
// a waiting output beat holds the last step until it is taken
module state_variable_filter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [svf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [svf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [svf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [svf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import svf_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_D_LO  = 13'b0000000000010,
    ST_D_HI  = 13'b0000000000100,
    ST_D_SUM = 13'b0000000001000,
    ST_H_LO  = 13'b0000000010000,
    ST_H_HI  = 13'b0000000100000,
    ST_G_LO  = 13'b0000001000000,
    ST_G_HI  = 13'b0000010000000,
    ST_G_SUM = 13'b0000100000000,
    ST_L_LO  = 13'b0001000000000,
    ST_L_HI  = 13'b0010000000000,
    ST_L_SUM = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;

  localparam logic signed [VAL_W:0] OUT_MAX = (VAL_W+1)'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [VAL_W:0] OUT_MIN = -((VAL_W+1)'(2 ** (SAMPLE_W - 1)));

  state_t                     state_r;
  state_t                     state_nxt;
  logic [SEL_W-1:0]           sel_r;
  logic [COEF_W-1:0]          g_r;
  logic [COEF_W-1:0]          damp_r;
  logic [COEF_W-1:0]          h_r;
  logic signed [SAMPLE_W:0]   x_r;
  val_t                       s1_r;
  val_t                       s2_r;
  val_t                       d_r;
  val_t                       hp_r;
  val_t                       bp_r;
  val_t                       lp_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  mul_ctl_t                   mctl;
  val_t                       m_opnd;
  logic [COEF_W-1:0]          m_coef;
  val_t                       m_res;

  logic                       wr_en;
  logic [1:0]                 reg_idx;
  logic                       out_load;
  val_t                       y;
  logic signed [VAL_W:0]      y_half;
  logic signed [SAMPLE_W-1:0] o_sat;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_SEL:  cfg_prdata = CFG_DATA_W'(sel_r);
      REG_G:    cfg_prdata = g_r;
      REG_DAMP: cfg_prdata = damp_r;
      REG_H:    cfg_prdata = h_r;
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r  <= RESP_LP;
      g_r    <= '0;
      damp_r <= '0;
      h_r    <= COEF_H_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEL:  sel_r  <= cfg_pwdata[SEL_W-1:0];
        REG_G:    g_r    <= cfg_pwdata;
        REG_DAMP: damp_r <= cfg_pwdata;
        REG_H:    h_r    <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // multiplier operand and pass select
  always_comb begin
    mctl   = '0;
    m_opnd = s1_r;
    m_coef = g_r;
    case (state_r)
      ST_D_LO, ST_D_HI: begin
        mctl.lo_en  = (state_r == ST_D_LO);
        mctl.hi_en  = (state_r == ST_D_HI);
        mctl.frac24 = 1'b1;
        m_opnd      = s1_r;
        m_coef      = damp_r;
      end
      ST_H_LO, ST_H_HI: begin
        mctl.lo_en = (state_r == ST_H_LO);
        mctl.hi_en = (state_r == ST_H_HI);
        m_opnd     = d_r;
        m_coef     = h_r;
      end
      ST_G_LO: begin
        mctl.lo_en = 1'b1;
        m_opnd     = m_res;
      end
      ST_G_HI: begin
        mctl.hi_en = 1'b1;
        m_opnd     = hp_r;
      end
      ST_L_LO, ST_L_HI: begin
        mctl.lo_en = (state_r == ST_L_LO);
        mctl.hi_en = (state_r == ST_L_HI);
        m_opnd     = bp_r;
      end
      default: begin
      end
    endcase
  end

  svf_mulc u_mulc (
    .clk  (clk),
    .ctl  (mctl),
    .opnd (m_opnd),
    .coef (m_coef),
    .res  (m_res)
  );

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    case (sel_r)
      RESP_LP: y = lp_r;
      RESP_BP: y = bp_r;
      RESP_HP: y = hp_r;
      default: y = '0;
    endcase
    y_half = ((VAL_W+1)'(y) + (VAL_W+1)'(1)) >>> 1;
    if (y_half > OUT_MAX) begin
      o_sat = OUT_MAX[SAMPLE_W-1:0];
    end else if (y_half < OUT_MIN) begin
      o_sat = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      o_sat = y_half[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_D_LO;
      ST_D_LO:  state_nxt = ST_D_HI;
      ST_D_HI:  state_nxt = ST_D_SUM;
      ST_D_SUM: state_nxt = ST_H_LO;
      ST_H_LO:  state_nxt = ST_H_HI;
      ST_H_HI:  state_nxt = ST_G_LO;
      ST_G_LO:  state_nxt = ST_G_HI;
      ST_G_HI:  state_nxt = ST_G_SUM;
      ST_G_SUM: state_nxt = ST_L_LO;
      ST_L_LO:  state_nxt = ST_L_HI;
      ST_L_HI:  state_nxt = ST_L_SUM;
      ST_L_SUM: state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      s1_r        <= '0;
      s2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        s2_r        <= sat_val((ext(lp_r) <<< 1) - ext(s2_r));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_L_LO) begin
        s1_r <= sat_val((ext(bp_r) <<< 1) - ext(s1_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      x_r <= {in_sample_in, 1'b0};
    end
    if (state_r == ST_D_SUM) begin
      d_r <= sat_val(SUM_W'(x_r) - ext(m_res) - ext(s2_r));
    end
    if (state_r == ST_G_LO) begin
      hp_r <= m_res;
    end
    if (state_r == ST_G_SUM) begin
      bp_r <= sat_val(ext(m_res) + ext(s1_r));
    end
    if (state_r == ST_L_SUM) begin
      lp_r <= sat_val(ext(m_res) + ext(s2_r));
    end
    if (out_load) begin
      out_data_r <= o_sat;
    end
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_D_LO)
    else $error("accepted beat did not start the sequence");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && !out_ready |=> state_r == ST_FIN)
    else $error("result step left while output beat pending");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> s1_r == '0 && s2_r == '0 && !out_valid_r)
    else $error("integrators not cleared by reset");
`endif

endmodule

// ===== tb/sv/state_variable_filter_core_test.sv =====
// state_variable_filter_core_test: self-checking bench for the filter core, with its own
// fixed-point predictor of the three responses and random handshake stalls on both sides
// depends on svf_pkg and state_variable_filter_core
module state_variable_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svf_pkg::*;

  localparam int PHASES = 10;
  localparam int PHASE_LEN = 195;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint VMAX = 64'sd549755813887;
  localparam longint VMIN = -64'sd549755813888;
  localparam longint OMAX = 64'sd8388607;
  localparam longint OMIN = -64'sd8388608;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 24'sh800000;
  localparam logic [SEL_W-1:0] RESP_NONE = 2'd3;

  class svf_scoreboard;
    logic [SEL_W-1:0] sel;
    logic [COEF_W-1:0] g, damp, h;
    longint s1, s2;
    logic signed [SAMPLE_W-1:0] due_samples[$];
    int errors, inputs_seen, outputs_seen;

    function new();
      sel = RESP_LP;
      g = '0;
      damp = '0;
      h = COEF_H_RST;
      s1 = 0;
      s2 = 0;
      errors = 0;
      inputs_seen = 0;
      outputs_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SEL: sel = value[SEL_W-1:0];
        REG_G: g = value;
        REG_DAMP: damp = value;
        REG_H: h = value;
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // c * s / 2^frac, rounded half up, saturated to 40 bits
    function longint scale_round(logic [COEF_W-1:0] c, longint s, int frac);
      logic signed [79:0] cw, sw, p, half;
      cw = {48'd0, c};
      sw = s;
      half = 80'sd1 <<< (frac - 1);
      p = (cw * sw + half) >>> frac;
      if (p > VMAX) return VMAX;
      if (p < VMIN) return VMIN;
      return longint'(p);
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] smp);
      longint x, d, hp, bp, lp, y;
      x = 2 * longint'(smp);
      d = clip(x - scale_round(damp, s1, FRAC_D) - s2, VMIN, VMAX);
      hp = scale_round(h, d, FRAC_G);
      bp = clip(scale_round(g, hp, FRAC_G) + s1, VMIN, VMAX);
      lp = clip(scale_round(g, bp, FRAC_G) + s2, VMIN, VMAX);
      s1 = clip(2 * bp - s1, VMIN, VMAX);
      s2 = clip(2 * lp - s2, VMIN, VMAX);
      case (sel)
        RESP_LP: y = lp;
        RESP_BP: y = bp;
        RESP_HP: y = hp;
        default: y = 0;
      endcase
      due_samples.push_back(SAMPLE_W'(clip((y + 1) >>> 1, OMIN, OMAX)));
      inputs_seen++;
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      outputs_seen++;
      if (due_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, expected none, actual %0d", $time, got);
        return;
      end
      want = due_samples.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return due_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  svf_scoreboard board = new();
  logic steady = 1'b0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;
  int settings = 0;
  int cycles = 0;
  logic [SEL_W-1:0] resp_cycle [4] = '{RESP_LP, RESP_BP, RESP_HP, RESP_NONE};

  state_variable_filter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // output side: check accepted beats, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) board.check_output(out_sample_out);
      out_ready <= rst_n && (steady || $urandom_range(99) >= 31);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= v;
    do @(posedge clk); while (!in_ready);
    board.note_input(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] selw, input logic [COEF_W-1:0] g,
                           input logic [COEF_W-1:0] damp, input logic [COEF_W-1:0] h);
    drain();
    write_reg(REG_SEL, selw);
    write_reg(REG_G, g);
    write_reg(REG_DAMP, damp);
    write_reg(REG_H, h);
    settings++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    int mid;
    case ($urandom_range(9))
      0: v = $urandom_range(1) ? SMAX : SMIN;
      1, 2: v = SAMPLE_W'($urandom());
      3, 4, 5, 6: begin
        mid = int'($urandom_range(131071)) - 65536;
        v = mid[SAMPLE_W-1:0];
      end
      default: v = last_sample;
    endcase
    last_sample = v;
    return v;
  endfunction

  task automatic run_phase(input int p);
    logic [CFG_DATA_W-1:0] selw;
    logic [COEF_W-1:0] g, damp, h;
    selw = $urandom();
    selw[SEL_W-1:0] = resp_cycle[p % 4];
    if (p == 3) begin
      g = '0;
      damp = '0;
      h = '0;
    end else if (p == 6) begin
      g = '1;
      damp = '1;
      h = '1;
    end else if (p == 8) begin
      g = '1;
      damp = '0;
      h = $urandom_range(32'h1000_0000, 32'h0100_0000);
    end else begin
      g = $urandom_range(32'd400_000_000, 32'd2_000_000);
      damp = (g >> 4) + $urandom_range(32'h0400_0000, 32'h0010_0000);
      h = $urandom_range(32'h1000_0000, 32'h0100_0000);
    end
    write_all(selw, g, damp, h);
    steady = (p == 5);
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (i == PHASE_LEN / 2) drain();
      send_sample(pick_sample());
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: lowpass stays at zero
    send_sample('0);
    send_sample(SMAX);
    send_sample(SMIN);
    // highpass with zero gain passes the input through
    drain();
    write_reg(REG_SEL, CFG_DATA_W'(RESP_HP));
    settings++;
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample('0);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    // full-scale coefficients drive the integrators into saturation
    write_all({30'h3FFF_FFFF, RESP_BP}, '1, '1, '1);
    send_sample(SMAX);
    send_sample(SMIN);
    send_sample(SMAX);
    send_sample('0);
    // unused selector gives zero while states still move
    drain();
    write_reg(REG_SEL, '1);
    send_sample(SMIN);
    send_sample(24'sd1);
    send_sample('0);
    // zero normalizer, then a moderate one
    write_all({30'h2AAA_AAAA, RESP_LP}, 32'h1000_0000, 32'h0200_0000, '0);
    send_sample(SMAX);
    send_sample(SMIN);
    drain();
    write_reg(REG_H, 32'h0555_5555);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    send_sample(SMAX);

    for (int p = 0; p < PHASES; p++) run_phase(p);
    drain();

    $display("%0d samples sent, %0d output beats checked over %0d register settings",
             board.inputs_seen, board.outputs_seen, settings);
    $display("covered lowpass, bandpass, highpass, the unused selector, zero and full-scale gains");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
